// ===== src/fnpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fnpa_pkg;

	// default pool capacity in nodes
	localparam int MAX_NODES_DEF = 1024;

	// divisor width: node size plus two index bytes
	localparam int DEN_W = 17;

	// configuration port
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_POOL_BASE  = 2'd0;
	localparam logic [1:0] REG_POOL_BYTES = 2'd1;
	localparam logic [1:0] REG_NODE_SIZE  = 2'd2;

	// register values after reset
	localparam logic [31:0] POOL_BASE_RST  = 32'd0;
	localparam logic [23:0] POOL_BYTES_RST = 24'd3;
	localparam logic [15:0] NODE_SIZE_RST  = 16'd1;
	// 3 / (1 + 2) nodes, one byte each
	localparam int NODE_TOTAL_RST = 1;
	localparam int AREA_RST       = 1;

	// operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;

	// result status codes
	localparam logic [2:0] ST_ALLOCATED = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_FREED     = 3'd2;
	localparam logic [2:0] ST_NOT_POOL  = 3'd3;
	localparam logic [2:0] ST_COUNT     = 3'd4;

endpackage

`default_nettype wire

// ===== src/fnpa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fnpa_div #(
	parameter int QW = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [31:0]                  dividend,
	input  wire logic [fnpa_pkg::DEN_W-1:0]   divisor,
	output logic                              done,
	output logic [QW-1:0]                     quotient
);
	import fnpa_pkg::*;

	localparam int DW = QW + DEN_W;
	localparam int RW = (DW > 32) ? DW : 32;
	localparam int SW = (QW > 1) ? $clog2(QW) : 1;

	logic [RW-1:0] rem_q;
	logic [RW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	// one quotient bit per cycle, most significant first
	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= SW'(QW - 1);
		end else begin
			done_q <= busy_q && (step_q == '0);
			if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - SW'(1);
				end
			end
		end
	end

	// datapath: restoring shift-subtract
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dividend);
			dsh_q <= RW'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= QW'({quo_q, ge});
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/fixed_node_pool_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Fixed-size node pool allocator. The region at pool_base of pool_bytes bytes holds
// pool_bytes / (node size + 2) nodes, capped at MAX_NODES; free node indexes sit on
// a stack in one synchronous memory, with a low-water mark standing for the initial
// content so no fill pass is needed. One item is worked at a time; a finished result
// waits in the output register while the next item is taken. An allocate goes through
// a stack read, an index multiply and a base add; a free waits on the shift-subtract
// divider that turns the offset into a node index; query and rejected items go straight
// to the output state. Every write to a register restarts the pool; the node count is
// then recomputed, on the same divider unless the region fills MAX_NODES, and the item
// side stalls until it is done.
// The stack memory is never cleared; only written entries are ever used.
module fixed_node_pool_allocator #(
	parameter int MAX_NODES = fnpa_pkg::MAX_NODES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fnpa_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// item channel
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    op,
	input  wire logic [31:0]                   node_address,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [2:0]                         status,
	output logic [31:0]                        alloc_address,
	output logic [15:0]                        free_count
);
	import fnpa_pkg::*;

	localparam int QW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW  = $clog2(MAX_NODES + 1);
	localparam int PW  = CW + DEN_W;
	localparam int ARW = CW + 16;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_ALOAD = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_OUT   = 4'd4;
	localparam logic [3:0] S_RCHK  = 4'd5;
	localparam logic [3:0] S_RCMP  = 4'd6;
	localparam logic [3:0] S_RDIV  = 4'd7;
	localparam logic [3:0] S_RAREA = 4'd8;

	logic [31:0]       pool_base_q;
	logic [23:0]       pool_bytes_q;
	logic [15:0]       node_size_q;
	logic [3:0]        state_q;
	logic [1:0]        op_q;
	logic [31:0]       addr_q;
	logic [CW-1:0]     free_top_q;
	logic [CW-1:0]     low_water_q;
	logic [CW-1:0]     node_total_q;
	logic [ARW-1:0]    area_q;
	logic              imp_q;
	logic [QW-1:0]     idx_imp_q;
	logic [PW-1:0]     prod_q;
	logic [2:0]        res_status_q;
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [31:0]       out_addr_q;
	logic [15:0]       out_count_q;

	logic [QW-1:0]     stack_mem [MAX_NODES];
	logic [QW-1:0]     rd_q;

	logic              cfg_wr;
	logic              cfg_restart;
	logic              item_acc;
	logic [15:0]       nb_eff;
	logic [DEN_W-1:0]  den_cfg;
	logic [CW-1:0]     pos;
	logic [QW-1:0]     pos_a;
	logic [31:0]       diff;
	logic              in_range;
	logic              sat;
	logic              div_start;
	logic [31:0]       div_dividend;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [QW-1:0]     div_quo;
	logic              mem_we;
	logic [QW-1:0]     idx_sel;
	logic              out_free;

	// configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	// only the listed registers restart the pool
	assign cfg_restart = cfg_wr
		&& (paddr[3:2] inside {REG_POOL_BASE, REG_POOL_BYTES, REG_NODE_SIZE});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q  <= POOL_BASE_RST;
			pool_bytes_q <= POOL_BYTES_RST;
			node_size_q  <= NODE_SIZE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_POOL_BASE:  pool_base_q  <= pwdata;
				REG_POOL_BYTES: pool_bytes_q <= pwdata[23:0];
				REG_NODE_SIZE:  node_size_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POOL_BASE:  prdata = pool_base_q;
			REG_POOL_BYTES: prdata = 32'(pool_bytes_q);
			REG_NODE_SIZE:  prdata = 32'(node_size_q);
			default:        prdata = '0;
		endcase
	end

	// derived operands
	assign nb_eff   = (node_size_q == '0) ? 16'd1 : node_size_q;
	assign den_cfg  = DEN_W'(nb_eff) + DEN_W'(2);
	assign pos      = free_top_q - CW'(1);
	assign pos_a    = pos[QW-1:0];
	assign diff     = addr_q - pool_base_q;
	assign in_range = (addr_q >= pool_base_q) && (diff < 32'(area_q))
		&& (free_top_q < node_total_q);
	assign sat      = (PW'(pool_bytes_q) >= prod_q);
	assign item_acc = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !result_stall;

	// shared divider: free offset by node size, or region by node plus index bytes
	assign div_start = ((state_q == S_EXEC) && (op_q == OP_FREE) && in_range)
		|| ((state_q == S_RCMP) && !sat);
	assign div_dividend = (state_q == S_RCMP) ? 32'(pool_bytes_q) : diff;
	assign div_den      = (state_q == S_RCMP) ? den_cfg : DEN_W'(nb_eff);

	fnpa_div #(
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// free index stack memory
	assign mem_we = (state_q == S_DIV) && div_done;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[free_top_q[QW-1:0]] <= div_quo;
		end
		rd_q <= stack_mem[pos_a];
	end

	assign idx_sel = imp_q ? idx_imp_q : rd_q;

	// control sequencer and stack pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			free_top_q   <= CW'(NODE_TOTAL_RST);
			low_water_q  <= CW'(NODE_TOTAL_RST);
			node_total_q <= CW'(NODE_TOTAL_RST);
			area_q       <= ARW'(AREA_RST);
			res_status_q <= ST_COUNT;
		end else if (cfg_restart) begin
			state_q <= S_RCHK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_ALLOC) begin
						if (free_top_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_OUT;
						end else begin
							if (pos < low_water_q) begin
								low_water_q <= pos;
							end
							free_top_q   <= pos;
							res_status_q <= ST_ALLOCATED;
							state_q      <= S_ALOAD;
						end
					end else if (op_q == OP_FREE) begin
						if (in_range) begin
							state_q <= S_DIV;
						end else begin
							res_status_q <= ST_NOT_POOL;
							state_q      <= S_OUT;
						end
					end else begin
						res_status_q <= ST_COUNT;
						state_q      <= S_OUT;
					end
				end
				S_ALOAD: begin
					state_q <= S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						if (free_top_q < low_water_q) begin
							low_water_q <= free_top_q;
						end
						free_top_q   <= free_top_q + CW'(1);
						res_status_q <= ST_FREED;
						state_q      <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RCHK: begin
					state_q <= S_RCMP;
				end
				S_RCMP: begin
					if (sat) begin
						node_total_q <= CW'(MAX_NODES);
						state_q      <= S_RAREA;
					end else begin
						state_q <= S_RDIV;
					end
				end
				S_RDIV: begin
					if (div_done) begin
						node_total_q <= CW'(div_quo);
						state_q      <= S_RAREA;
					end
				end
				S_RAREA: begin
					area_q      <= ARW'(node_total_q) * ARW'(nb_eff);
					free_top_q  <= node_total_q;
					low_water_q <= node_total_q;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload and datapath registers
	always_ff @(posedge clk) begin
		if (item_acc) begin
			op_q   <= op;
			addr_q <= node_address;
		end
		if (state_q == S_EXEC) begin
			imp_q     <= (pos < low_water_q);
			idx_imp_q <= QW'(node_total_q - CW'(1) - pos);
		end
		if (state_q == S_ALOAD) begin
			prod_q <= PW'(idx_sel) * PW'(nb_eff);
		end else if (state_q == S_RCHK) begin
			prod_q <= PW'(den_cfg) * PW'(MAX_NODES);
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_status_q <= res_status_q;
			out_addr_q   <= (res_status_q == ST_ALLOCATED)
				? pool_base_q + 32'(prod_q) : '0;
			out_count_q  <= 16'(free_top_q);
		end
	end

	assign result_valid  = out_valid_q;
	assign status        = out_status_q;
	assign alloc_address = out_addr_q;
	assign free_count    = out_count_q;

`ifndef SYNTHESIS
	// free count never exceeds the node count while waiting for an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (free_top_q <= node_total_q))
		else $error("free count above node total");

	// implicit region always lies below the stack top
	assert property (@(posedge clk) disable iff (!arst_n)
		low_water_q <= free_top_q)
		else $error("low-water mark above stack top");

	// a new result beat only comes from the output state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	// stack writes stay inside the node count
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (free_top_q < node_total_q))
		else $error("stack push beyond node total");
`endif

endmodule

`default_nettype wire
